>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/spp_pkg.sv
// Types, constants and helper functions of the starfield point projector.
`timescale 1ns / 1ps
package spp_pkg;

  localparam int DVD_W  = 27;  // magnitude of a coordinate times 3200
  localparam int DVS_W  = 15;  // divisor width (advanced depth)
  localparam int Z_W    = 15;
  localparam int N_LANE = 2;

  localparam int LANE_X  = 0;  // x * 3200 / z
  localparam int LANE_Y  = 1;  // y * 3200 / z

  // y * 3200 / 457 is 7y + y / 457; the second term uses a reciprocal multiply.
  localparam logic [15:0]      Y_RECIP       = 16'd36712;  // 2^24 / 457 rounded up
  localparam int               Y_RECIP_SHIFT = 24;

  localparam logic [Z_W-1:0]   NEAR_LIMIT = 15'd3200;
  localparam logic [15:0]      X_CENTER   = 16'd640;
  localparam logic [15:0]      Y_CENTER   = 16'd200;
  localparam logic [14:0]      X_LIMIT    = 15'd639;
  localparam logic [15:0]      Y_LIMIT    = 16'd400;
  localparam logic [Z_W-1:0]   FAR_SHADE  = 15'd26000;
  localparam logic [Z_W-1:0]   MID_SHADE  = 15'd20000;
  localparam logic [3:0]       SHADE_HI   = 4'd8;
  localparam logic [7:0]       MASK_HIDE  = 8'hff;
  localparam logic [7:0]       MASK_MSB   = 8'h80;

  typedef enum logic [1:0] {
    REG_DEPTH_SPEED = 2'd0,
    REG_PAGE_BASE   = 2'd1,
    REG_KEEP_DEPTH  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] star_x;
    logic signed [15:0] star_y;
    logic signed [15:0] star_depth;
    logic [7:0]         star_tint;
  } star_in_t;

  typedef struct packed {
    logic [14:0] new_depth;
    logic        visible;
    logic [15:0] pixel_address;
    logic [2:0]  pixel_bit;
    logic [7:0]  bit_mask;
    logic [3:0]  pixel_color;
    logic [15:0] record_word;
    logic        record_word_write;
  } star_out_t;

  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    logic [Z_W-1:0] z;
    logic           neg_x;
    logic           neg_y;
    logic [7:0]     tint;
    logic           hide_near;
  } star_ctx_t;

  typedef struct packed {
    star_ctx_t                    ctx;
    div_lane_t [N_LANE-1:0]       lane;
  } div_pipe_t;

  // Magnitude times 3200 (2048 + 1024 + 128) by shifts and adds.
  function automatic logic [DVD_W-1:0] scale_3200(input logic [15:0] a);
    logic [DVD_W-1:0] e;
    e = DVD_W'(a);
    return (e << 11) + (e << 10) + (e << 7);
  endfunction

  // Absolute value of a 16-bit signed number as an unsigned 16-bit value.
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

endpackage

>>> hw/rtl/spp_front.sv
// Input stage: depth advance, operand magnitudes and the near cull.
`timescale 1ns / 1ps
module spp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  spp_pkg::star_in_t star,
  input  logic [15:0]       depth_speed,
  output logic              vld,
  output spp_pkg::div_pipe_t pipe
);
  import spp_pkg::*;

  logic [15:0]      depth_sum;
  logic [Z_W-1:0]   z;
  logic [15:0]      ax;
  logic [15:0]      ay;
  logic [16:0]      five_x;
  logic [18:0]      seven_y;
  logic [31:0]      frac_prod;
  logic [15:0]      near_y;
  logic [DVD_W-1:0] prod_x;
  logic [DVD_W-1:0] prod_y;
  logic             hide_n;
  div_pipe_t        pipe_next;

  // A negative advanced depth keeps its low 15 bits, so z is always the low 15 bits.
  assign depth_sum = 16'(star.star_depth) + depth_speed;
  assign z         = depth_sum[Z_W-1:0];

  assign ax     = mag16(star.star_x);
  assign ay     = mag16(star.star_y);
  assign prod_x = scale_3200(ax);
  assign prod_y = scale_3200(ay);

  // x * 3200 / 640 is exactly 5x; its magnitude is compared modulo 65536.
  assign five_x  = (17'(ax) << 2) + 17'(ax);

  // y * 3200 / 457 is 7y plus y / 457, the latter by reciprocal multiplication.
  assign seven_y   = (19'(ay) << 3) - 19'(ay);
  assign frac_prod = 32'(ay) * 32'(Y_RECIP);
  assign near_y    = seven_y[15:0] + 16'(frac_prod[31:Y_RECIP_SHIFT]);

  assign hide_n = (z <= NEAR_LIMIT)
                  && ((five_x[15:0] >= 16'(z)) || (near_y >= 16'(z)));

  always_comb begin
    pipe_next.ctx.z         = z;
    pipe_next.ctx.neg_x     = star.star_x[15];
    pipe_next.ctx.neg_y     = star.star_y[15];
    pipe_next.ctx.tint      = star.star_tint;
    pipe_next.ctx.hide_near = hide_n;
    pipe_next.lane[LANE_X]  = '{rem: '0, dvd: prod_x, dvs: z};
    pipe_next.lane[LANE_Y]  = '{rem: '0, dvd: prod_y, dvs: z};
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe <= pipe_next;
    end
  end

endmodule

>>> hw/rtl/spp_div_stage.sv
// One restoring-division step for each lane, with its stage register.
`timescale 1ns / 1ps
module spp_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  spp_pkg::div_pipe_t in_pipe,
  output logic               vld,
  output spp_pkg::div_pipe_t pipe
);
  import spp_pkg::*;

  div_pipe_t pipe_next;

  // Shift the next dividend bit into the remainder and subtract the divisor when it fits.
  // The quotient bit enters the dividend word from the bottom.
  always_comb begin
    logic [DVS_W:0] t;
    logic [DVS_W:0] diff;
    logic           ge;
    pipe_next = in_pipe;
    for (int i = 0; i < N_LANE; i++) begin
      t    = {in_pipe.lane[i].rem, in_pipe.lane[i].dvd[DVD_W-1]};
      diff = t - {1'b0, in_pipe.lane[i].dvs};
      ge   = (t >= {1'b0, in_pipe.lane[i].dvs});
      pipe_next.lane[i].rem = ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
      pipe_next.lane[i].dvd = {in_pipe.lane[i].dvd[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe <= pipe_next;
    end
  end

endmodule

>>> hw/rtl/spp_back.sv
// Output stages: screen position, culling, address, mask and shade.
`timescale 1ns / 1ps
module spp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  spp_pkg::div_pipe_t in_pipe,
  input  logic [15:0]        page_base,
  input  logic               keep_depth_mode,
  output logic               vld,
  output spp_pkg::star_out_t result
);
  import spp_pkg::*;

  logic [15:0]    qx;
  logic [15:0]    qy;
  logic [15:0]    px_next;
  logic [15:0]    py_next;
  logic           hide_next;

  logic           s1_vld;
  logic [Z_W-1:0] s1_z;
  logic [7:0]     s1_tint;
  logic [15:0]    s1_px;
  logic [15:0]    s1_py;
  logic           s1_hide;

  logic           vis;
  logic [7:0]     pyh;
  logic [15:0]    addr;
  logic [2:0]     bit_idx;
  logic [3:0]     color;
  star_out_t      result_next;

  // Only the low 16 bits of each signed quotient matter after the centre offset.
  assign qx  = in_pipe.lane[LANE_X].dvd[15:0];
  assign qy  = in_pipe.lane[LANE_Y].dvd[15:0];

  assign px_next   = (in_pipe.ctx.neg_x ? 16'(-qx) : qx) + X_CENTER;
  assign py_next   = (in_pipe.ctx.neg_y ? 16'(-qy) : qy) + Y_CENTER;
  assign hide_next = in_pipe.ctx.hide_near;

  // First stage register: centred coordinates and near-cull outcome.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_z    <= in_pipe.ctx.z;
      s1_tint <= in_pipe.ctx.tint;
      s1_px   <= px_next;
      s1_py   <= py_next;
      s1_hide <= hide_next;
    end
  end

  // Screen bounds: x on the halved grid, y before halving.
  assign vis = !s1_hide && !s1_px[15] && (s1_px[15:1] < X_LIMIT)
               && !s1_py[15] && (s1_py < Y_LIMIT);

  // Row times 80 is row times 64 plus row times 16.
  assign pyh     = s1_py[8:1];
  assign bit_idx = s1_px[3:1];
  assign addr    = 16'({pyh, 6'b0}) + 16'({pyh, 4'b0}) + 16'(s1_px[10:4]) + page_base;

  // Depth shading: far stars take SHADE_HI alone, near stars get SHADE_HI added to the tint.
  assign color = (s1_z > FAR_SHADE) ? SHADE_HI
                 : (((s1_z < MID_SHADE) ? SHADE_HI : 4'd0) + s1_tint[3:0]);

  always_comb begin
    result_next           = '0;
    result_next.new_depth = s1_z;
    if (vis) begin
      result_next.visible           = 1'b1;
      result_next.pixel_address     = addr;
      result_next.pixel_bit         = bit_idx;
      result_next.bit_mask          = MASK_MSB >> bit_idx;
      result_next.pixel_color       = color;
      result_next.record_word       = addr;
      result_next.record_word_write = 1'b1;
    end else begin
      result_next.bit_mask = MASK_HIDE;
      if (keep_depth_mode) begin
        result_next.record_word       = 16'(s1_z);
        result_next.record_word_write = 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

>>> hw/rtl/starfield_point_projector.sv
// Top level of the starfield point projector: configuration and the pipeline.
//
//   Channel  Signals                           Direction  Payload
//   star     star_valid / star_ready           in         star_in_t record
//   result   result_valid / result_ready       out        star_out_t record
//   cfg      cfg_valid / cfg_ready             in         cfg_index, cfg_data
//
// One star enters per cycle unless the result is stalled; its result passes through
// one input stage, 27 divider stages (one quotient bit per stage, two lanes)
// and two output stages. Synchronous reset clears the valid bits and config registers.
// A stalled result holds the whole pipeline in place; star_ready follows it.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
module starfield_point_projector (
  input  logic               clk,
  input  logic               rst,
  input  logic               star_valid,
  output logic               star_ready,
  input  spp_pkg::star_in_t  star,
  output logic               result_valid,
  input  logic               result_ready,
  output spp_pkg::star_out_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import spp_pkg::*;

  logic [15:0] depth_speed;
  logic [15:0] page_base;
  logic        keep_depth_mode;
  logic        en;
  logic        vld  [0:DVD_W];
  div_pipe_t   pipe [0:DVD_W];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_speed     <= '0;
      page_base       <= '0;
      keep_depth_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEPTH_SPEED: depth_speed     <= cfg_data;
        REG_PAGE_BASE:   page_base       <= cfg_data;
        REG_KEEP_DEPTH:  keep_depth_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is waiting to be taken.
  assign en         = !result_valid || result_ready;
  assign star_ready = en;

  spp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_vld      (star_valid),
    .star        (star),
    .depth_speed (depth_speed),
    .vld         (vld[0]),
    .pipe        (pipe[0])
  );

  for (genvar s = 0; s < DVD_W; s++) begin : g_div
    spp_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (vld[s]),
      .in_pipe (pipe[s]),
      .vld     (vld[s+1]),
      .pipe    (pipe[s+1])
    );
  end

  spp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_vld          (vld[DVD_W]),
    .in_pipe         (pipe[DVD_W]),
    .page_base       (page_base),
    .keep_depth_mode (keep_depth_mode),
    .vld             (result_valid),
    .result          (result)
  );

endmodule

>>> hw/rtl/spp_checker.sv
// Port checker for the starfield point projector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spp_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input spp_pkg::star_out_t result
);
  import spp_pkg::*;

  // A stalled result stays presented and unchanged.
  `ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

  // A hidden star carries the full mask.
  `ASSERT_IMP(a_hidden_mask, result_valid && !result.visible, result.bit_mask == MASK_HIDE, "hidden star without full mask")

  // A plotted star stores its address in the record word.
  `ASSERT_IMP(a_visible_record, result_valid && result.visible, result.record_word_write && (result.record_word == result.pixel_address), "visible record word mismatch")

  // A plotted star's mask selects exactly its bit.
  `ASSERT_IMP(a_visible_mask, result_valid && result.visible, $onehot(result.bit_mask) && (result.bit_mask == (MASK_MSB >> result.pixel_bit)), "mask and bit index disagree")

endmodule

bind starfield_point_projector spp_checker u_spp_checker (.*);

>>> test/starfield_point_projector_tb.sv
// Testbench for the starfield point projector: random and directed star records.
`timescale 1ns / 1ps
module starfield_point_projector_tb;
  import spp_pkg::*;

  localparam int LATENCY = 30;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;
  logic star_valid;
  logic star_ready;
  star_in_t star;
  logic result_valid;
  logic result_ready;
  star_out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  // Projector settings as the predictor sees them.
  logic signed [15:0] speed_q;
  logic [15:0] page_q;
  logic keep_q;

  star_in_t pending_stars[$];
  star_out_t expected_points[$];
  int errors;
  int watchdog;
  bit calm;
  bit star_taken;

  starfield_point_projector uut (
    .clk(clk), .rst(rst),
    .star_valid(star_valid), .star_ready(star_ready), .star(star),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // True when the near cull hides the star.
  function automatic bit near_hidden(input int product, input int divisor, input int z);
    int q;
    int mag;
    if (z > 3200) return 1'b0;
    q = product / divisor;
    mag = (q < 0) ? -q : q;
    return (mag & 32'hffff) >= z;
  endfunction

  function automatic logic signed [15:0] low16(input int v);
    return v[15:0];
  endfunction

  // Predicted screen point for one star under the current settings.
  function automatic star_out_t project_star(input star_in_t s);
    star_out_t o;
    int x, y, z, px, py, colour;
    logic [15:0] addr;
    bit shown;
    x = s.star_x;
    y = s.star_y;
    z = low16(int'(s.star_depth) + int'(speed_q));
    if (z < 0) z = z & 32'h7fff;
    o = '0;
    o.new_depth = z[14:0];
    shown = !near_hidden(x * 3200, 640, z);
    if (shown) begin
      px = low16((x * 3200) / z + 640);
      if (px < 0) shown = 1'b0;
      else begin
        px = px >>> 1;
        if (px >= 639) shown = 1'b0;
      end
    end
    if (shown && near_hidden(y * 3200, 457, z)) shown = 1'b0;
    if (shown) begin
      py = low16((y * 3200) / z + 200);
      if (py < 0 || py >= 400) shown = 1'b0;
      else py = py >>> 1;
    end
    if (!shown) begin
      o.bit_mask = 8'hff;
      if (keep_q) begin
        o.record_word = z[15:0];
        o.record_word_write = 1'b1;
      end
    end else begin
      addr = 16'(py * 80 + (px >> 3) + page_q);
      colour = (z > 26000) ? 8 : ((z < 20000 ? 8 : 0) + s.star_tint);
      o.visible = 1'b1;
      o.pixel_address = addr;
      o.pixel_bit = px[2:0];
      o.bit_mask = 8'h80 >> px[2:0];
      o.pixel_color = colour[3:0];
      o.record_word = addr;
      o.record_word_write = 1'b1;
    end
    return o;
  endfunction

  // Star transfers as seen at the rising edge.
  always @(posedge clk) begin
    star_taken <= star_valid && star_ready;
  end

  // Driver: star transfers, changed at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      star_valid <= 1'b0;
      star <= '0;
    end else if (!star_valid || star_taken) begin
      if (pending_stars.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
        star <= pending_stars[0];
        expected_points.push_back(project_star(pending_stars[0]));
        void'(pending_stars.pop_front());
        star_valid <= 1'b1;
      end else begin
        star_valid <= 1'b0;
      end
    end
  end

  // Sink stalls.
  always @(negedge clk) begin
    result_ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 33);
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    star_out_t e;
    if (!rst && result_valid && result_ready) begin
      if (expected_points.size() == 0) begin
        $error("result transfer with no prediction waiting");
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (result.new_depth !== e.new_depth) begin
          $error("new_depth: expected %0d actual %0d", e.new_depth, result.new_depth); errors++;
        end
        if (result.visible !== e.visible) begin
          $error("visible: expected %0d actual %0d", e.visible, result.visible); errors++;
        end
        if (result.pixel_address !== e.pixel_address) begin
          $error("pixel_address: expected %0d actual %0d", e.pixel_address,
                 result.pixel_address); errors++;
        end
        if (result.pixel_bit !== e.pixel_bit) begin
          $error("pixel_bit: expected %0d actual %0d", e.pixel_bit, result.pixel_bit); errors++;
        end
        if (result.bit_mask !== e.bit_mask) begin
          $error("bit_mask: expected %0d actual %0d", e.bit_mask, result.bit_mask); errors++;
        end
        if (result.pixel_color !== e.pixel_color) begin
          $error("pixel_color: expected %0d actual %0d", e.pixel_color,
                 result.pixel_color); errors++;
        end
        if (result.record_word !== e.record_word) begin
          $error("record_word: expected %0d actual %0d", e.record_word,
                 result.record_word); errors++;
        end
        if (result.record_word_write !== e.record_word_write) begin
          $error("record_word_write: expected %0d actual %0d", e.record_word_write,
                 result.record_word_write); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (star_valid && star_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      watchdog <= 0;
    else if (pending_stars.size() > 0 || expected_points.size() > 0) begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Register write, only while the pipeline is empty.
  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEPTH_SPEED: speed_q = value;
      REG_PAGE_BASE:   page_q = value;
      default:         keep_q = value[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pending_stars.size() > 0 || expected_points.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic push_star(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] d, input logic [7:0] t);
    star_in_t s;
    s.star_x = x;
    s.star_y = y;
    s.star_depth = d;
    s.star_tint = t;
    pending_stars.push_back(s);
  endtask

  // Random stars: mostly plausible on-screen ones, some full-range noise.
  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70)
        push_star(16'($signed($urandom_range(800)) - 400),
                  16'($signed($urandom_range(600)) - 300),
                  16'($urandom_range(30000)), 8'($urandom));
      else if ($urandom_range(1) == 1)
        push_star(16'($signed($urandom_range(40)) - 20),
                  16'($signed($urandom_range(40)) - 20),
                  16'($urandom_range(3300)), 8'($urandom));
      else
        push_star(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_DEPTH_SPEED;
    cfg_data = '0;
    speed_q = '0;
    page_q = '0;
    keep_q = 1'b0;
    errors = 0;
    watchdog = 0;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed stars: centre, zero depth, near culls, edges, shade bands, wraps.
    write_reg(REG_DEPTH_SPEED, 16'd0);
    write_reg(REG_PAGE_BASE, 16'd0);
    write_reg(REG_KEEP_DEPTH, 16'd1);
    push_star(16'd0, 16'd0, 16'd100, 8'd3);
    push_star(16'd0, 16'd0, 16'd0, 8'd0);
    push_star(16'd10, 16'd0, 16'd3200, 8'd1);
    push_star(16'd1000, 16'd5, 16'd3200, 8'd1);
    push_star(16'd5, 16'd1000, 16'd3200, 8'd1);
    push_star(16'h7fff, 16'h7fff, 16'h7fff, 8'hff);
    push_star(16'h8000, 16'h8000, 16'h8000, 8'h00);
    push_star(-16'sd200, -16'sd62, 16'd1000, 8'd7);
    push_star(16'd199, 16'd62, 16'd1000, 8'd7);
    push_star(16'd0, 16'd0, 16'd26000, 8'd5);
    push_star(16'd0, 16'd0, 16'd26001, 8'd5);
    push_star(16'd0, 16'd0, 16'd19999, 8'd5);
    push_star(16'd0, 16'd0, 16'd20000, 8'd5);
    push_star(16'd3, 16'd4, 16'hffff, 8'd9);
    drain_pipeline();
    write_reg(REG_DEPTH_SPEED, 16'h7fff);
    write_reg(REG_PAGE_BASE, 16'hffff);
    push_star(16'd0, 16'd0, 16'd5, 8'd2);
    push_star(16'd100, 16'd100, 16'h7fff, 8'd2);
    push_star(-16'sd5, 16'd0, -16'sd20000, 8'd2);
    drain_pipeline();

    // Random phases across several settings, extremes included.
    write_reg(REG_DEPTH_SPEED, 16'd0);
    write_reg(REG_PAGE_BASE, 16'd0);
    write_reg(REG_KEEP_DEPTH, 16'd0);
    push_random(100);
    drain_pipeline();
    write_reg(REG_DEPTH_SPEED, 16'h8000);
    write_reg(REG_PAGE_BASE, 16'hffff);
    write_reg(REG_KEEP_DEPTH, 16'd1);
    push_random(100);
    drain_pipeline();
    write_reg(REG_DEPTH_SPEED, 16'($urandom_range(400)) - 16'd200);
    write_reg(REG_PAGE_BASE, 16'($urandom));
    calm = 1'b1;
    push_random(150);
    drain_pipeline();
    calm = 1'b0;
    write_reg(REG_DEPTH_SPEED, 16'($urandom));
    write_reg(REG_KEEP_DEPTH, 16'd0);
    push_random(150);
    drain_pipeline();

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
